[hw/rtl/timer_ctc_pwm_event_counter_unit_assert.svh]
// Assertion macros for the timer unit.
// Define ASSERT_OFF to compile the checks out.
`ifndef TIMER_CTC_PWM_EVENT_COUNTER_UNIT_ASSERT_SVH
`define TIMER_CTC_PWM_EVENT_COUNTER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define TCPEC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tcpec: assertion failed");

// Check that post holds in the cycle after pre.
`define TCPEC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tcpec: assertion failed");

`else

`define TCPEC_ASSERT(label, clk, rst, prop)
`define TCPEC_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

[hw/rtl/tcpec_pkg.sv]
package tcpec_pkg;

   localparam int COUNT_WIDTH    = 16;
   localparam int PRESCALE_WIDTH = 10;

   // Operating modes
   localparam logic [2:0] MODE_CMP_REPEAT = 3'd0;
   localparam logic [2:0] MODE_CMP_ONCE   = 3'd1;
   localparam logic [2:0] MODE_PWM        = 3'd2;
   localparam logic [2:0] MODE_CNT_ONCE   = 3'd3;
   localparam logic [2:0] MODE_CNT_REPEAT = 3'd4;

   // Clock sources
   localparam logic [2:0] CS_DIV1    = 3'd0;
   localparam logic [2:0] CS_DIV8    = 3'd1;
   localparam logic [2:0] CS_DIV64   = 3'd2;
   localparam logic [2:0] CS_DIV256  = 3'd3;
   localparam logic [2:0] CS_DIV1024 = 3'd4;
   localparam logic [2:0] CS_EXT_FALL = 3'd5;
   localparam logic [2:0] CS_EXT_RISE = 3'd6;

   // Request actions
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_STOP  = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_MODE         = 2'd0;
   localparam logic [1:0] CSR_CLOCK_SELECT = 2'd1;
   localparam logic [1:0] CSR_TOP_VALUE    = 2'd2;
   localparam logic [1:0] CSR_EVENT_ENABLE = 2'd3;

   localparam logic [COUNT_WIDTH-1:0] TOP_RESET = '1;

   typedef struct packed {
      logic [2:0]             mode;
      logic [2:0]             clock_select;
      logic [COUNT_WIDTH-1:0] top_value;
      logic                   event_enable;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0]    count;
      logic [PRESCALE_WIDTH-1:0] prescale;
      logic                      count_down;
      logic                      running;
      logic                      last_pin;
      logic                      wave;
   } timer_state_type;

   typedef struct packed {
      logic                   running;
      logic                   wave_out;
      logic                   match_event;
      logic [COUNT_WIDTH-1:0] count_now;
   } result_type;

   // Prescaler terminal count for an internal clock source
   function automatic logic [PRESCALE_WIDTH:0] prescale_limit(input logic [2:0] sel);
      logic [PRESCALE_WIDTH:0] lim;
      case (sel)
         CS_DIV1:   lim = (PRESCALE_WIDTH+1)'(1);
         CS_DIV8:   lim = (PRESCALE_WIDTH+1)'(8);
         CS_DIV64:  lim = (PRESCALE_WIDTH+1)'(64);
         CS_DIV256: lim = (PRESCALE_WIDTH+1)'(256);
         default:   lim = (PRESCALE_WIDTH+1)'(1024);
      endcase
      return lim;
   endfunction

endpackage

[hw/rtl/tcpec_tick_gen.sv]
module tcpec_tick_gen (
   input  tcpec_pkg::cfg_type                      cfg,
   input  logic [tcpec_pkg::PRESCALE_WIDTH-1:0]    prescale,
   input  logic                                    last_pin,
   input  logic                                    pin,
   output logic                                    tick,
   output logic [tcpec_pkg::PRESCALE_WIDTH-1:0]    prescale_next
);
   import tcpec_pkg::*;

   logic [PRESCALE_WIDTH:0] ps_inc;
   logic                    counter_mode;

   assign ps_inc       = {1'b0, prescale} + (PRESCALE_WIDTH+1)'(1);
   assign counter_mode = (cfg.mode == MODE_CNT_ONCE) || (cfg.mode == MODE_CNT_REPEAT);

   // Pick the timer clock source: prescaler (not in the counter modes) or pin edge
   always_comb begin
      tick          = 1'b0;
      prescale_next = prescale;
      case (cfg.clock_select)
         CS_DIV1, CS_DIV8, CS_DIV64, CS_DIV256, CS_DIV1024: begin
            if (!counter_mode) begin
               if (ps_inc >= prescale_limit(cfg.clock_select)) begin
                  tick          = 1'b1;
                  prescale_next = '0;
               end else begin
                  prescale_next = ps_inc[PRESCALE_WIDTH-1:0];
               end
            end
         end
         CS_EXT_FALL: tick = last_pin && !pin;
         CS_EXT_RISE: tick = !last_pin && pin;
         default:     tick = 1'b0;
      endcase
   end

endmodule

[hw/rtl/tcpec_step.sv]
module tcpec_step (
   input  tcpec_pkg::cfg_type          cfg,
   input  tcpec_pkg::timer_state_type  state,
   input  logic [1:0]                  action,
   input  logic                        pin,
   output tcpec_pkg::timer_state_type  state_next,
   output tcpec_pkg::result_type       result
);
   import tcpec_pkg::*;

   logic                      tick;
   logic [PRESCALE_WIDTH-1:0] ps_next;
   logic [COUNT_WIDTH-1:0]    half_top;
   logic [COUNT_WIDTH-1:0]    cnt;
   logic                      hit;
   logic                      mode_ok;

   tcpec_tick_gen u_tick_gen (
      .cfg           (cfg),
      .prescale      (state.prescale),
      .last_pin      (state.last_pin),
      .pin           (pin),
      .tick          (tick),
      .prescale_next (ps_next)
   );

   assign half_top = cfg.top_value >> 1;
   assign mode_ok  = (cfg.mode == MODE_CMP_REPEAT) || (cfg.mode == MODE_CMP_ONCE) ||
                     (cfg.mode == MODE_PWM) || (cfg.mode == MODE_CNT_ONCE) ||
                     (cfg.mode == MODE_CNT_REPEAT);

   // Apply one request to the timer state
   always_comb begin
      state_next          = state;
      state_next.last_pin = pin;
      hit                 = 1'b0;
      cnt                 = state.count;
      case (action)
         ACT_START: begin
            state_next.count      = '0;
            state_next.prescale   = '0;
            state_next.count_down = 1'b0;
            state_next.wave       = 1'b1;
            state_next.running    = 1'b1;
         end
         ACT_STOP: state_next.running = 1'b0;
         ACT_TICK: begin
            if (state.running && mode_ok) begin
               state_next.prescale = ps_next;
               if (tick) begin
                  if (cfg.mode == MODE_PWM) begin
                     // Dual slope: up to top, then down to zero
                     if (!state.count_down) begin
                        if (state.count < cfg.top_value) begin
                           cnt = state.count + COUNT_WIDTH'(1);
                           if (cnt == cfg.top_value) begin
                              state_next.count_down = 1'b1;
                              hit                   = 1'b1;
                           end
                        end else begin
                           cnt                   = cfg.top_value;
                           state_next.count_down = 1'b1;
                           hit                   = 1'b1;
                        end
                     end else begin
                        if (state.count != '0) begin
                           cnt = state.count - COUNT_WIDTH'(1);
                        end
                        if (cnt == '0) begin
                           state_next.count_down = 1'b0;
                        end
                     end
                     // Clear on the way up, set on the way down
                     if (cnt == half_top) begin
                        state_next.wave = state.count_down;
                     end
                  end else begin
                     // Single slope: wrap at top
                     if (state.count == cfg.top_value) begin
                        cnt = '0;
                        hit = 1'b1;
                        if (cfg.mode == MODE_CMP_ONCE || cfg.mode == MODE_CNT_ONCE) begin
                           state_next.running = 1'b0;
                        end
                     end else begin
                        cnt = state.count + COUNT_WIDTH'(1);
                     end
                  end
                  state_next.count = cnt;
               end
            end
         end
         default: state_next.last_pin = pin;
      endcase
   end

   // Form the result from the updated state
   always_comb begin
      result.count_now   = state_next.count;
      result.match_event = hit && cfg.event_enable;
      result.wave_out    = (cfg.mode == MODE_PWM) ? state_next.wave : 1'b0;
      result.running     = state_next.running;
   end

endmodule

[hw/rtl/timer_ctc_pwm_event_counter_unit.sv]
// Flow: a request accepted into the input register moves to the response register
//   once that is empty or being read, and its response is offered from there.
// Throughput: one request per cycle while the response side is not stalled; the timer
//   state updates in one pass of the step logic, which closes the state loop.
// Reset: synchronous; clears both valid flags and the timer state, and loads
//   the registers with their reset values (top value all ones, wave level high).
`include "timer_ctc_pwm_event_counter_unit_assert.svh"

module timer_ctc_pwm_event_counter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] ext_pin_level, [7:1] zero
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] count_now, [16] match_event,
                                    // [17] wave_out, [18] running, [23:19] zero
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import tcpec_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [1:0]      in_action_ff;
   logic            in_pin_ff;
   logic            out_valid_ff, out_valid_in;
   result_type      out_data_ff;
   cfg_type         cfg_ff, cfg_in;
   timer_state_type state_ff, state_step;
   result_type      step_result;
   logic            advance;

   // Move the held request into the response stage
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MODE:         cfg_in.mode         = csr_wdata[2:0];
            CSR_CLOCK_SELECT: cfg_in.clock_select = csr_wdata[2:0];
            CSR_TOP_VALUE:    cfg_in.top_value    = csr_wdata[COUNT_WIDTH-1:0];
            CSR_EVENT_ENABLE: cfg_in.event_enable = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   tcpec_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .action     (in_action_ff),
      .pin        (in_pin_ff),
      .state_next (state_step),
      .result     (step_result)
   );

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff.mode         <= MODE_CMP_REPEAT;
         cfg_ff.clock_select <= CS_DIV1;
         cfg_ff.top_value    <= TOP_RESET;
         cfg_ff.event_enable <= 1'b0;
         state_ff.count      <= '0;
         state_ff.prescale   <= '0;
         state_ff.count_down <= 1'b0;
         state_ff.running    <= 1'b0;
         state_ff.last_pin   <= 1'b0;
         state_ff.wave       <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) begin
            state_ff <= state_step;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_action_ff <= req_tuser;
         in_pin_ff    <= req_tdata[0];
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_data_ff.running, out_data_ff.wave_out,
                        out_data_ff.match_event, out_data_ff.count_now};

   `TCPEC_ASSERT(a_match_needs_enable, clock, reset, rsp_tvalid && rsp_tdata[16] |-> cfg_ff.event_enable)
   `TCPEC_ASSERT(a_wave_only_pwm, clock, reset, rsp_tvalid && rsp_tdata[17] |-> cfg_ff.mode == MODE_PWM)
   `TCPEC_ASSERT_NEXT(a_start_clears, clock, reset, advance && in_action_ff == ACT_START, rsp_tdata[15:0] == '0 && rsp_tdata[18])
   `TCPEC_ASSERT_NEXT(a_stop_halts, clock, reset, advance && in_action_ff == ACT_STOP, !rsp_tdata[18])

endmodule
